// ----- hw/rtl/tlvp_pkg.sv -----
// Shared types, constants and tag decoding for the tagged line value parser.
package tlvp_pkg;

    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_PRINT_MIN = 8'h20;
    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam int         VALUE_SKIP     = 2;
    localparam int         MIN_LINE       = 3;

    localparam logic [2:0] KEY_VOLTAGE = 3'd0;
    localparam logic [2:0] KEY_CURRENT = 3'd1;
    localparam logic [2:0] KEY_POWER   = 3'd2;
    localparam logic [2:0] KEY_CHARGE  = 3'd3;
    localparam logic [2:0] KEY_ENERGY  = 3'd4;
    localparam logic [2:0] KEY_TIME    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] code;
    } tag_t;

    typedef struct packed {
        logic [2:0] key_code;
        logic [7:0] char_value;
        logic       last;
    } out_word_t;

    function automatic tag_t tag_decode(input logic [7:0] c);
        tag_t t;
        t.ok   = 1'b1;
        t.code = KEY_VOLTAGE;
        case (c)
            8'h55: t.code = KEY_VOLTAGE;
            8'h49: t.code = KEY_CURRENT;
            8'h50: t.code = KEY_POWER;
            8'h43: t.code = KEY_CHARGE;
            8'h45: t.code = KEY_ENERGY;
            8'h74: t.code = KEY_TIME;
            default: t.ok = 1'b0;
        endcase
        return t;
    endfunction

endpackage

// ----- hw/rtl/tlvp_ram.sv -----
// Generic simple dual-port RAM with registered read.
module tlvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tlvp_ctrl.sv -----
// Line fill control, readout sequencer and output word register.
module tlvp_ctrl #(
    parameter int LINE_LEN      = 20,
    parameter int VALUE_MAX_LEN = 20,
    localparam int AW = $clog2(LINE_LEN),
    localparam int FW = $clog2(LINE_LEN + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output tlvp_pkg::out_word_t m_word,
    output logic                ram_we,
    output logic [AW-1:0]       ram_waddr,
    output logic [7:0]          ram_wdata,
    output logic                ram_re,
    output logic [AW-1:0]       ram_raddr,
    input  logic [7:0]          ram_rdata
);

    tlvp_pkg::state_t    state_reg, state_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [FW-1:0]       rd_idx_reg, rd_idx_next;
    logic [FW-1:0]       rd_end_reg, rd_end_next;
    logic [2:0]          key_reg, key_next;
    logic                tag_ok_reg, tag_ok_next;
    logic                m_valid_reg;
    tlvp_pkg::out_word_t m_word_reg;

    logic                accept, is_lf, is_print, emit_line, slot_free, rd_more, load;
    logic [FW-1:0]       rd_idx_inc, line_end;
    tlvp_pkg::out_word_t load_word;
    tlvp_pkg::tag_t      tag;

    assign accept     = s_valid && s_ready;
    assign is_lf      = (s_rx_byte == tlvp_pkg::BYTE_LF);
    assign is_print   = (s_rx_byte >= tlvp_pkg::BYTE_PRINT_MIN);
    assign emit_line  = tag_ok_reg && (int'(fill_reg) >= tlvp_pkg::MIN_LINE);
    assign slot_free  = !m_valid_reg || m_ready;
    assign rd_idx_inc = rd_idx_reg + FW'(1);
    assign rd_more    = (rd_idx_inc < rd_end_reg);
    assign line_end   = (int'(fill_reg) > VALUE_MAX_LEN) ? FW'(VALUE_MAX_LEN) : fill_reg;
    assign tag        = tlvp_pkg::tag_decode(s_rx_byte);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlvp_pkg::ST_IDLE: begin
                if (accept && is_lf && emit_line) begin
                    state_next = tlvp_pkg::ST_DATA;
                end
            end
            tlvp_pkg::ST_DATA: begin
                if (slot_free && !rd_more) begin
                    state_next = tlvp_pkg::ST_TAIL;
                end
            end
            tlvp_pkg::ST_TAIL: begin
                if (slot_free) begin
                    state_next = tlvp_pkg::ST_IDLE;
                end
            end
            default: state_next = tlvp_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        s_ready     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = rd_idx_inc[AW-1:0];
        load        = 1'b0;
        load_word   = '{key_code: key_reg, char_value: ram_rdata, last: 1'b0};
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        rd_end_next = rd_end_reg;
        key_next    = key_reg;
        tag_ok_next = tag_ok_reg;
        case (state_reg)
            tlvp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (is_lf) begin
                        fill_next   = '0;
                        rd_idx_next = FW'(tlvp_pkg::VALUE_SKIP);
                        rd_end_next = line_end;
                        ram_re      = emit_line;
                        ram_raddr   = AW'(tlvp_pkg::VALUE_SKIP);
                    end else if (is_print && (fill_reg < FW'(LINE_LEN))) begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + FW'(1);
                        if (fill_reg == '0) begin
                            key_next    = tag.code;
                            tag_ok_next = tag.ok;
                        end
                    end
                end
            end
            tlvp_pkg::ST_DATA: begin
                if (slot_free) begin
                    load = 1'b1;
                    if (rd_more) begin
                        ram_re      = 1'b1;
                        rd_idx_next = rd_idx_inc;
                    end
                end
            end
            tlvp_pkg::ST_TAIL: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_word = '{key_code: key_reg, char_value: tlvp_pkg::BYTE_SPACE,
                                  last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    assign ram_waddr = fill_reg[AW-1:0];
    assign ram_wdata = s_rx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tlvp_pkg::ST_IDLE;
            fill_reg    <= '0;
            tag_ok_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            tag_ok_reg <= tag_ok_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        rd_end_reg <= rd_end_next;
        key_reg    <= key_next;
        if (load) begin
            m_word_reg <= load_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ----- hw/rtl/tagged_line_value_parser.sv -----
// Top level of the tagged line value parser.
// Input channel s_*: one received byte per word on s_rx_byte. Printable bytes
// (0x20 and up) fill a line store of LINE_LEN entries; extra bytes are dropped,
// other control bytes are ignored. A line feed (0x0A) closes the line.
// Output channel m_*: on a line feed after a line of three or more characters
// whose first is U, I, P, C, E or t, the characters from position 2 on come out
// one per word with m_key_code set, at most VALUE_MAX_LEN-2 of them, followed
// by a space word with m_last high. Other lines produce no words.
// Timing: a line feed's first word passes the RAM read register and then the
// output register; further words follow one per cycle while m_ready is high,
// and the space word comes last. The line store RAM delivers one character
// per cycle unless the output stalls. s_ready is low while a line is read out.
// Reset (aresetn low, synchronous) empties the line and drops any pending
// output word. When m_ready is low the output register holds its word and
// readout pauses; a byte can be taken while the last word waits.
module tagged_line_value_parser #(
    parameter int LINE_LEN      = 20,
    parameter int VALUE_MAX_LEN = 20
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_key_code,
    output logic [7:0] m_char_value,
    output logic       m_last
);

    localparam int AW = $clog2(LINE_LEN);

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;
    tlvp_pkg::out_word_t m_word;

    tlvp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tlvp_ctrl #(
        .LINE_LEN      (LINE_LEN),
        .VALUE_MAX_LEN (VALUE_MAX_LEN)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign m_key_code   = m_word.key_code;
    assign m_char_value = m_word.char_value;
    assign m_last       = m_word.last;

endmodule
